FILE: src/pgsd_pkg.sv
// Shared widths, register codes, store control type and saturation helper
// for the PCM gain and splice de-click block. No dependencies.
package pgsd_pkg;

  localparam int SMP_W        = 32;
  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W        = 4;
  localparam int MAX_SEGMENT  = 4096;
  localparam int SEG_W        = 13;
  localparam int GAIN_W       = 17;
  localparam int RATE_W       = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ENABLE = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_BYPASS = 17'd65530;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 17'd65536;
  localparam logic [RATE_W-1:0] RATE_RESET  = 20'd44100;

  // rate/200 = ((rate >> 3) * 167773) >> 22, exact for any 20-bit rate
  localparam int RATE_PRE_SHIFT  = 3;
  localparam int RATE_POST_SHIFT = 22;
  localparam int RECIP_W         = 18;
  localparam logic [RECIP_W-1:0] RATE_RECIP = 18'd167773;
  localparam logic [SEG_W-1:0] RAMP_ZERO_RATE = 13'd220;
  localparam logic [SEG_W-1:0] MIN_RAMP       = 13'd2;

  // Serial multiply-accumulate: signed multiplicand, unsigned multiplier bits
  localparam int MAC_AW = SMP_W + 1;
  localparam int MAC_BW = GAIN_W;
  localparam int ACC_W  = MAC_AW + MAC_BW;

  // Serial divider: quotient bits, divisor bits, dividend bits
  localparam int DIV_QW = 34;
  localparam int DIV_DW = SEG_W;
  localparam int DIV_NW = DIV_QW + DIV_DW;

  localparam int SAT_W = 35;

  localparam logic signed [SAT_W-1:0] S32_HI = 35'sh0_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] S32_LO = -35'sh0_8000_0000;
  localparam logic signed [SAT_W-1:0] S16_HI = 35'sd32767;
  localparam logic signed [SAT_W-1:0] S16_LO = -35'sd32768;

  typedef struct packed {
    logic            last_we;
    logic            first_we;
    logic [CH_W-1:0] idx;
  } pgsd_store_ctl_t;

  // Clamp to the configured sample width; 16-bit results come back sign-extended.
  function automatic logic [SMP_W-1:0] sat(input logic signed [SAT_W-1:0] x,
                                           input logic w32);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic [SMP_W-1:0]        y;
    hi = w32 ? S32_HI : S16_HI;
    lo = w32 ? S32_LO : S16_LO;
    if (x > hi) begin
      y = hi[SMP_W-1:0];
    end else if (x < lo) begin
      y = lo[SMP_W-1:0];
    end else begin
      y = x[SMP_W-1:0];
    end
    return y;
  endfunction

endpackage

FILE: src/pgsd_serial_mac.sv
// Shift-add multiply-accumulate, one multiplier bit per cycle for two pairs.
// Depends on pgsd_pkg for widths.
module pgsd_serial_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [pgsd_pkg::MAC_AW-1:0]    a0,
  input  logic        [pgsd_pkg::MAC_BW-1:0]    b0,
  input  logic signed [pgsd_pkg::MAC_AW-1:0]    a1,
  input  logic        [pgsd_pkg::MAC_BW-1:0]    b1,
  output logic                                  done,
  output logic signed [pgsd_pkg::ACC_W-1:0]     acc
);

  localparam int CNT_W = $clog2(pgsd_pkg::MAC_BW);

  logic                                 run_r;
  logic                                 done_r;
  logic [CNT_W-1:0]                     cnt_r;
  logic signed [pgsd_pkg::ACC_W-1:0]    a0_r;
  logic signed [pgsd_pkg::ACC_W-1:0]    a1_r;
  logic [pgsd_pkg::MAC_BW-1:0]          b0_r;
  logic [pgsd_pkg::MAC_BW-1:0]          b1_r;
  logic signed [pgsd_pkg::ACC_W-1:0]    acc_r;
  logic signed [pgsd_pkg::ACC_W-1:0]    acc_nxt;

  always_comb begin
    acc_nxt = acc_r + (b0_r[0] ? a0_r : '0) + (b1_r[0] ? a1_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pgsd_pkg::MAC_BW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a0_r  <= pgsd_pkg::ACC_W'(a0);
      a1_r  <= pgsd_pkg::ACC_W'(a1);
      b0_r  <= b0;
      b1_r  <= b1;
      acc_r <= '0;
    end else if (run_r) begin
      // advance one multiplier bit: shift multiplicands up, multipliers down
      acc_r <= acc_nxt;
      a0_r  <= a0_r <<< 1;
      a1_r  <= a1_r <<< 1;
      b0_r  <= b0_r >> 1;
      b1_r  <= b1_r >> 1;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

FILE: src/pgsd_serial_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pgsd_pkg; the caller guarantees the quotient fits DIV_QW bits.
module pgsd_serial_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pgsd_pkg::DIV_NW-1:0]   num,
  input  logic [pgsd_pkg::DIV_DW-1:0]   den,
  output logic                          done,
  output logic [pgsd_pkg::DIV_QW-1:0]   quo
);

  localparam int CNT_W = $clog2(pgsd_pkg::DIV_QW);

  logic                          run_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [pgsd_pkg::DIV_DW-1:0]   rem_r;
  logic [pgsd_pkg::DIV_DW-1:0]   rem_nxt;
  logic [pgsd_pkg::DIV_DW-1:0]   den_r;
  logic [pgsd_pkg::DIV_QW-1:0]   q_r;
  logic [pgsd_pkg::DIV_DW:0]     trial;
  logic                          qbit;

  always_comb begin
    trial   = {rem_r, q_r[pgsd_pkg::DIV_QW-1]};
    qbit    = trial >= {1'b0, den_r};
    rem_nxt = qbit ? pgsd_pkg::DIV_DW'(trial - {1'b0, den_r})
                   : trial[pgsd_pkg::DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pgsd_pkg::DIV_QW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper dividend bits are already below the divisor
      rem_r <= num[pgsd_pkg::DIV_NW-1:pgsd_pkg::DIV_QW];
      q_r   <= num[pgsd_pkg::DIV_QW-1:0];
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[pgsd_pkg::DIV_QW-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: src/pgsd_frame_store.sv
// Per-channel last-output and first-ramp-frame sample stores.
// Depends on pgsd_pkg for the store control struct and widths.
module pgsd_frame_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pgsd_pkg::pgsd_store_ctl_t      ctl,
  input  logic [pgsd_pkg::SMP_W-1:0]     last_wdata,
  input  logic [pgsd_pkg::SMP_W-1:0]     first_wdata,
  output logic [pgsd_pkg::SMP_W-1:0]     last_rdata,
  output logic [pgsd_pkg::SMP_W-1:0]     first_rdata
);

  logic [pgsd_pkg::SMP_W-1:0] last_r  [pgsd_pkg::MAX_CHANNELS];
  logic [pgsd_pkg::SMP_W-1:0] first_r [pgsd_pkg::MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pgsd_pkg::MAX_CHANNELS; i++) begin
        last_r[i]  <= '0;
        first_r[i] <= '0;
      end
    end else begin
      if (ctl.last_we) begin
        last_r[ctl.idx] <= last_wdata;
      end
      if (ctl.first_we) begin
        first_r[ctl.idx] <= first_wdata;
      end
    end
  end

  assign last_rdata  = last_r[ctl.idx];
  assign first_rdata = first_r[ctl.idx];

endmodule

FILE: src/pcm_gain_and_splice_declick.sv
// PCM gain and splice de-click top level; uses pgsd_pkg, pgsd_serial_mac,
// pgsd_serial_div and pgsd_frame_store. One transaction in, one out.
// Steps: segment bookkeeping, then finish; volume adds a multiply before them, a
// ramp adds a multiply and a divide between them (one shift-add multiplier, shared
// by volume and ramp, and one restoring divider). An input is taken only while
// idle; the next one is taken while a result still waits. Sync active-low reset.
module pcm_gain_and_splice_declick (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pgsd_pkg::SMP_W-1:0]         in_sample,
  input  logic                               in_new_segment,
  input  logic [pgsd_pkg::SEG_W-1:0]         in_segment_frames,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pgsd_pkg::SMP_W-1:0]         out_sample_out,
  output logic                               out_ramp_active,
  input  logic                               cfg_we,
  input  logic [pgsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for a transaction
  localparam logic [2:0] ST_VOL   = 3'd1;  // volume multiply running
  localparam logic [2:0] ST_SEG   = 3'd2;  // segment / channel bookkeeping
  localparam logic [2:0] ST_RPREP = 3'd3;  // launch ramp multiply
  localparam logic [2:0] ST_RMUL  = 3'd4;  // ramp multiply running
  localparam logic [2:0] ST_RDIV  = 3'd5;  // ramp divide running
  localparam logic [2:0] ST_FIN   = 3'd6;  // commit state, load output

  localparam int SMP_W = pgsd_pkg::SMP_W;
  localparam int SEG_W = pgsd_pkg::SEG_W;
  localparam int CH_W  = pgsd_pkg::CH_W;
  localparam int NCH_W = pgsd_pkg::NCH_W;
  localparam int ACC_W = pgsd_pkg::ACC_W;
  localparam int SAT_W = pgsd_pkg::SAT_W;
  localparam int PROD_W = (pgsd_pkg::RATE_W - pgsd_pkg::RATE_PRE_SHIFT) + pgsd_pkg::RECIP_W;

  logic [2:0] state_r;

  // Configuration registers
  logic [NCH_W-1:0]            channels_r;
  logic                        width32_r;
  logic [pgsd_pkg::RATE_W-1:0] rate_r;
  logic [pgsd_pkg::GAIN_W-1:0] gain_r;
  logic                        vol_en_r;
  logic                        smooth_en_r;

  // Stream state
  logic                        lfv_r;
  logic [CH_W-1:0]             chpos_r;
  logic [SEG_W-1:0]            ramp_pos_r;
  logic [SEG_W-1:0]            ramp_len_r;
  logic                        ramp_run_r;

  // Per-transaction working registers
  logic [SMP_W-1:0]            vs_r;
  logic                        newseg_r;
  logic [SEG_W-1:0]            seg_r;
  logic [CH_W-1:0]             c_r;
  logic [SMP_W-1:0]            res_r;
  logic                        active_r;
  logic                        neg_r;
  logic [SEG_W-1:0]            rl_r;

  // Output register
  logic                        out_valid_r;
  logic [SMP_W-1:0]            out_sample_r;
  logic                        out_ramp_r;

  // Arithmetic units: the multiplier is shared by volume and ramp
  logic                                mac_start;
  logic signed [pgsd_pkg::MAC_AW-1:0]  mac_a0;
  logic [pgsd_pkg::MAC_BW-1:0]         mac_b0;
  logic signed [pgsd_pkg::MAC_AW-1:0]  mac_a1;
  logic [pgsd_pkg::MAC_BW-1:0]         mac_b1;
  logic                                mac_done;
  logic signed [ACC_W-1:0]             mac_acc;
  logic                                div_start;
  logic [pgsd_pkg::DIV_NW-1:0]         div_num;
  logic [pgsd_pkg::DIV_DW-1:0]         div_den;
  logic                                div_done;
  logic [pgsd_pkg::DIV_QW-1:0]         div_quo;

  pgsd_pkg::pgsd_store_ctl_t           st_ctl;
  logic [SMP_W-1:0]                    last_rd;
  logic [SMP_W-1:0]                    first_rd;

  // Combinational helpers
  logic                        in_acc;
  logic [SMP_W-1:0]            v_in;
  logic                        vol_on;
  logic [NCH_W-1:0]            nch;
  logic [CH_W-1:0]             pos0;
  logic [CH_W-1:0]             c_nxt;
  logic [SEG_W-1:0]            seg_cl;
  logic                        ramp_start;
  logic                        run_seg;
  logic [SEG_W-1:0]            pos_seg;
  logic [SEG_W-1:0]            len_cand;
  logic [SEG_W-1:0]            den;
  logic [SEG_W-1:0]            mult_m;
  logic [PROD_W-1:0]           rl_prod;
  logic [SEG_W-1:0]            rl_nxt;
  logic signed [ACC_W-1:0]     vol_sum;
  logic [SMP_W-1:0]            vol_res;
  logic                        acc_neg;
  logic [ACC_W-1:0]            acc_mag;
  logic [ACC_W:0]              num_full;
  logic signed [SAT_W-1:0]     quo_s;
  logic [SMP_W-1:0]            ramp_res;
  logic                        out_free;
  logic                        fin_load;
  logic                        frozen;
  logic [NCH_W-1:0]            c_inc;
  logic                        frame_end;
  logic [SEG_W-1:0]            ramp_pos_inc;
  logic                        fmt_write;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    // 16-bit mode uses the low half, sign-extended
    v_in   = width32_r ? in_sample : {{(SMP_W-16){in_sample[15]}}, in_sample[15:0]};
    vol_on = vol_en_r && (gain_r < pgsd_pkg::GAIN_BYPASS);

    if (channels_r == '0) begin
      nch = NCH_W'(1);
    end else if (channels_r > NCH_W'(pgsd_pkg::MAX_CHANNELS)) begin
      nch = NCH_W'(pgsd_pkg::MAX_CHANNELS);
    end else begin
      nch = channels_r;
    end

    // Ramp length limit from the sample rate: rate/200, 220 at zero, at least 2
    rl_prod = rate_r[pgsd_pkg::RATE_W-1:pgsd_pkg::RATE_PRE_SHIFT] * pgsd_pkg::RATE_RECIP;
    if (rate_r == '0) begin
      rl_nxt = pgsd_pkg::RAMP_ZERO_RATE;
    end else begin
      rl_nxt = rl_prod[pgsd_pkg::RATE_POST_SHIFT +: SEG_W];
      if (rl_nxt < pgsd_pkg::MIN_RAMP) begin
        rl_nxt = pgsd_pkg::MIN_RAMP;
      end
    end

    // Segment start and channel selection
    pos0  = newseg_r ? '0 : chpos_r;
    c_nxt = ({1'b0, pos0} >= nch) ? '0 : pos0;
    seg_cl = (seg_r > SEG_W'(pgsd_pkg::MAX_SEGMENT)) ? SEG_W'(pgsd_pkg::MAX_SEGMENT) : seg_r;
    ramp_start = newseg_r && smooth_en_r && lfv_r && (seg_cl >= pgsd_pkg::MIN_RAMP);
    len_cand   = (seg_cl < rl_r) ? seg_cl : rl_r;
    run_seg    = newseg_r ? ramp_start : ramp_run_r;
    pos_seg    = ramp_start ? '0 : ramp_pos_r;

    den    = ramp_len_r - 1'b1;
    mult_m = den - ramp_pos_r;

    // Volume: round half away from zero, then >> 16 (Q16)
    vol_sum = mac_acc + ACC_W'(32768) - ACC_W'(mac_acc[ACC_W-1]);
    vol_res = pgsd_pkg::sat(SAT_W'(signed'(vol_sum[ACC_W-1:16])), width32_r);

    // Ramp: divide |num| rounded half away from zero by den
    acc_neg  = mac_acc[ACC_W-1];
    acc_mag  = acc_neg ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
    num_full = {acc_mag, 1'b0} + (ACC_W+1)'(den);
    div_num  = num_full[pgsd_pkg::DIV_NW-1:0];
    div_den  = pgsd_pkg::DIV_DW'({den, 1'b0});
    quo_s    = SAT_W'(div_quo);
    ramp_res = pgsd_pkg::sat(neg_r ? -quo_s : quo_s, width32_r);

    out_free  = !out_valid_r || out_ready;
    fin_load  = (state_r == ST_FIN) && out_free;
    // Hold the splice source steady until the last ramp frame
    frozen    = ramp_run_r && ((ramp_pos_r + 1'b1) < ramp_len_r);
    c_inc     = NCH_W'(c_r) + 1'b1;
    frame_end = c_inc >= nch;
    ramp_pos_inc = ramp_pos_r + 1'b1;

    fmt_write = cfg_we && ((cfg_index == pgsd_pkg::REG_CHANNELS) ||
                           (cfg_index == pgsd_pkg::REG_SAMPLE_WIDTH) ||
                           (cfg_index == pgsd_pkg::REG_SAMPLE_RATE));
  end

  // Multiplier and divider launches
  always_comb begin
    mac_start = 1'b0;
    mac_a0    = pgsd_pkg::MAC_AW'(signed'(v_in));
    mac_b0    = gain_r;
    mac_a1    = '0;
    mac_b1    = '0;
    div_start = 1'b0;
    if (state_r == ST_IDLE) begin
      mac_start = in_acc && vol_on;
    end else if (state_r == ST_RPREP) begin
      // v*den + (last - first)*(den - pos)
      mac_start = 1'b1;
      mac_a0    = pgsd_pkg::MAC_AW'(signed'(vs_r));
      mac_b0    = pgsd_pkg::MAC_BW'(den);
      mac_a1    = pgsd_pkg::MAC_AW'(signed'(last_rd)) - pgsd_pkg::MAC_AW'(signed'(first_rd));
      mac_b1    = pgsd_pkg::MAC_BW'(mult_m);
    end else if (state_r == ST_RMUL) begin
      div_start = mac_done;
    end
  end

  // Store control: first frame on ramp start, last output unless frozen
  always_comb begin
    st_ctl.first_we = 1'b0;
    st_ctl.last_we  = 1'b0;
    st_ctl.idx      = c_r;
    if (state_r == ST_SEG) begin
      st_ctl.idx      = c_nxt;
      st_ctl.first_we = run_seg && (pos_seg == '0);
    end else if (fin_load) begin
      st_ctl.last_we  = !frozen;
    end
  end

  // Sequencer and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      channels_r  <= NCH_W'(2);
      width32_r   <= 1'b0;
      rate_r      <= pgsd_pkg::RATE_RESET;
      gain_r      <= pgsd_pkg::GAIN_RESET;
      vol_en_r    <= 1'b0;
      smooth_en_r <= 1'b0;
      lfv_r       <= 1'b0;
      chpos_r     <= '0;
      ramp_pos_r  <= '0;
      ramp_len_r  <= '0;
      ramp_run_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= vol_on ? ST_VOL : ST_SEG;
          end
        end
        ST_VOL: begin
          if (mac_done) begin
            state_r <= ST_SEG;
          end
        end
        ST_SEG: begin
          if (newseg_r) begin
            ramp_run_r <= ramp_start;
            if (ramp_start) begin
              ramp_len_r <= len_cand;
              ramp_pos_r <= '0;
            end
          end
          state_r <= run_seg ? ST_RPREP : ST_FIN;
        end
        ST_RPREP: begin
          state_r <= ST_RMUL;
        end
        ST_RMUL: begin
          if (mac_done) begin
            state_r <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
            chpos_r <= frame_end ? '0 : CH_W'(c_inc);
            if (frame_end) begin
              lfv_r <= 1'b1;
              if (ramp_run_r) begin
                ramp_pos_r <= ramp_pos_inc;
                if (ramp_pos_inc >= ramp_len_r) begin
                  ramp_run_r <= 1'b0;
                end
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // Output register: drop on take, load on finish
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Configuration writes must arrive only while idle; the block does not enforce this
      if (cfg_we) begin
        unique case (cfg_index)
          pgsd_pkg::REG_CHANNELS:      channels_r  <= cfg_wdata[NCH_W-1:0];
          pgsd_pkg::REG_SAMPLE_WIDTH:  width32_r   <= cfg_wdata[0];
          pgsd_pkg::REG_SAMPLE_RATE:   rate_r      <= cfg_wdata[pgsd_pkg::RATE_W-1:0];
          pgsd_pkg::REG_GAIN_Q16:      gain_r      <= cfg_wdata[pgsd_pkg::GAIN_W-1:0];
          pgsd_pkg::REG_VOLUME_ENABLE: vol_en_r    <= cfg_wdata[0];
          pgsd_pkg::REG_SMOOTH_ENABLE: smooth_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      // A format change restarts the stream
      if (fmt_write) begin
        lfv_r      <= 1'b0;
        chpos_r    <= '0;
        ramp_pos_r <= '0;
        ramp_len_r <= '0;
        ramp_run_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rl_r <= rl_nxt;
    if (in_acc) begin
      vs_r     <= v_in;
      newseg_r <= in_new_segment;
      seg_r    <= in_segment_frames;
    end
    if ((state_r == ST_VOL) && mac_done) begin
      vs_r <= vol_res;
    end
    if (state_r == ST_SEG) begin
      c_r      <= c_nxt;
      res_r    <= vs_r;
      active_r <= run_seg;
    end
    if ((state_r == ST_RMUL) && mac_done) begin
      neg_r <= acc_neg;
    end
    if ((state_r == ST_RDIV) && div_done) begin
      res_r <= ramp_res;
    end
    if (fin_load) begin
      out_sample_r <= res_r;
      out_ramp_r   <= active_r;
    end
  end

  pgsd_serial_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a0    (mac_a0),
    .b0    (mac_b0),
    .a1    (mac_a1),
    .b1    (mac_b1),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  pgsd_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  pgsd_frame_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (st_ctl),
    .last_wdata  (res_r),
    .first_wdata (vs_r),
    .last_rdata  (last_rd),
    .first_rdata (first_rd)
  );

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_ramp_active = out_ramp_r;

endmodule
